// ----- rtl/core/gps_pkg.sv -----
// Package for the grid peak suppression unit: field widths, register
// indexes, default sizes and the clamped squaring helper used by the top level.
// Depends on nothing.
package gps_pkg;

    localparam int COORD_W  = 12;
    localparam int INDEX_W  = 20;
    localparam int CFG_W    = 9;
    localparam int CFG_IDX_W = 2;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 24;

    localparam int CELL_SUM_W = COORD_W + 1;

    localparam int DEF_GRID_SIDE        = 256;
    localparam int DEF_SUBCELL_BITS     = 4;
    localparam int DEF_MAX_RADIUS_CELLS = 16;

    localparam logic [CFG_IDX_W-1:0] REG_RADIUS      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd2;

    localparam logic [CFG_W-1:0] RADIUS_RESET      = 9'd160;
    localparam logic [CFG_W-1:0] GRID_WIDTH_RESET  = 9'd256;
    localparam logic [CFG_W-1:0] GRID_HEIGHT_RESET = 9'd256;

    // Offsets are compared in doubled units; the radius never exceeds 511, so
    // any offset of 1023 or more already lies outside every disc.
    localparam int MAG_W = CFG_W + 1;
    localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};
    localparam int SQ_W = 2 * MAG_W;

    function automatic logic [SQ_W-1:0] sq_clamp(input logic signed [31:0] d);
        logic [31:0]      mag;
        logic [MAG_W-1:0] m;
        mag = d[31] ? 32'(-d) : 32'(d);
        m   = (mag > 32'(MAG_MAX)) ? MAG_MAX : mag[MAG_W-1:0];
        return m * m;
    endfunction

endpackage

// ----- rtl/core/gps_disc_lanes.sv -----
// Column lanes of the suppression disc: holds the squared column offsets of
// the window and turns a row offset into the mark mask of one map row.
// Depends on gps_pkg.
module gps_disc_lanes #(
    parameter int GRID_SIDE        = gps_pkg::DEF_GRID_SIDE,
    parameter int MAX_RADIUS_CELLS = gps_pkg::DEF_MAX_RADIUS_CELLS
) (
    input  logic                              aclk,
    input  logic                              push,
    input  logic [gps_pkg::SQ_W-1:0]          push_sq,
    input  logic                              push_ok,
    input  logic [gps_pkg::SQ_W-1:0]          dysq,
    input  logic [gps_pkg::SQ_W-1:0]          lim,
    input  logic [$clog2(GRID_SIDE)-1:0]      cx,
    output logic [GRID_SIDE-1:0]              row_mask
);
    import gps_pkg::*;

    localparam int NL     = 2 * MAX_RADIUS_CELLS + 1;
    localparam int WIDE_W = GRID_SIDE + NL;

    logic [SQ_W-1:0] lane_sq_reg [NL];
    logic [NL-1:0]   lane_ok_reg;
    logic [NL-1:0]   hit;
    logic [WIDE_W-1:0] wide;

    always_ff @(posedge aclk) begin
        if (push) begin
            for (int i = 0; i < NL - 1; i++) begin
                lane_sq_reg[i] <= lane_sq_reg[i+1];
            end
            lane_sq_reg[NL-1] <= push_sq;
            lane_ok_reg       <= {push_ok, lane_ok_reg[NL-1:1]};
        end
    end

    always_comb begin
        for (int k = 0; k < NL; k++) begin
            hit[k] = lane_ok_reg[k] &&
                     (({1'b0, lane_sq_reg[k]} + {1'b0, dysq}) < {1'b0, lim});
        end
        wide     = WIDE_W'(hit) << cx;
        row_mask = wide[MAX_RADIUS_CELLS +: GRID_SIDE];
    end

endmodule

// ----- rtl/core/grid_peak_suppression_unit.sv -----
// Top level of the grid peak suppression unit: mark map memory, sequencer,
// configuration registers and output register.
// Depends on gps_pkg and gps_disc_lanes.
//
//  channel | direction | handshake           | word
//  s_      | in        | s_tvalid / s_tready | point or clear command
//  m_      | out       | m_tvalid / m_tready | index of a peak
//  cfg_    | in        | cfg_valid/cfg_ready | register index and value
//
// A point first passes its column lanes through the squaring unit, one lane a
// cycle, then marks one map row per memory access for each of the R map rows
// inside its window (at most 2*MAX_RADIUS_CELLS + 1). A clear word and the sweep
// after reset clear one row a cycle, with s_tready low. A held result stalls a
// point only when that point is also a peak. Configuration writes are taken in any cycle.
module grid_peak_suppression_unit #(
    parameter int GRID_SIDE        = gps_pkg::DEF_GRID_SIDE,
    parameter int SUBCELL_BITS     = gps_pkg::DEF_SUBCELL_BITS,
    parameter int MAX_RADIUS_CELLS = gps_pkg::DEF_MAX_RADIUS_CELLS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // point_x[11:0], point_y[23:12], point_index[43:24], zeros above
    input  logic [gps_pkg::S_TDATA_W-1:0]     s_tdata,
    // mode[0]
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // peak_index[19:0], zeros above
    output logic [gps_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gps_pkg::CFG_W-1:0]         cfg_data
);
    import gps_pkg::*;

    localparam int CW    = $clog2(GRID_SIDE);
    localparam int S     = 1 << SUBCELL_BITS;
    localparam int HALF  = S >> 1;
    localparam int NL    = 2 * MAX_RADIUS_CELLS + 1;
    localparam int KW    = $clog2(NL);
    localparam int CRW   = $clog2(MAX_RADIUS_CELLS + 1);
    localparam int COLW  = $clog2(GRID_SIDE + MAX_RADIUS_CELLS + 1) + 1;
    localparam int DXW   = $clog2((GRID_SIDE + MAX_RADIUS_CELLS) * 2 * S + 8192) + 1;
    localparam int RLIM  = MAX_RADIUS_CELLS * S;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_SETUP, ST_LANES, ST_CHECK, ST_MARK, ST_DRAIN
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0] radius_reg, radius_next;
    logic [CFG_W-1:0] grid_width_reg, grid_width_next;
    logic [CFG_W-1:0] grid_height_reg, grid_height_next;

    logic [CW-1:0]  row_reg, row_next;
    logic           st1_valid_reg, st1_valid_next;
    logic           m_tvalid_reg, m_tvalid_next;

    logic [COORD_W-1:0] px_reg, px_next, py_reg, py_next;
    logic [INDEX_W-1:0] idx_reg, idx_next;
    logic [INDEX_W-1:0] peak_reg, peak_next;
    logic [CW-1:0]      cx_reg, cx_next, y1_reg, y1_next, st1_row_reg, st1_row_next;
    logic [CRW-1:0]     cr_reg, cr_next;
    logic [SQ_W-1:0]    lim_reg, lim_next, dysq_reg, dysq_next;
    logic [KW-1:0]      k_reg, k_next;
    logic signed [DXW-1:0]  dx_reg, dx_next;
    logic signed [COLW-1:0] col_reg, col_next;

    logic [GRID_SIDE-1:0] mark_mem [GRID_SIDE];
    logic [GRID_SIDE-1:0] rd_data_reg;
    logic                 mem_re, mem_we;
    logic [CW-1:0]        mem_raddr, mem_waddr;
    logic [GRID_SIDE-1:0] mem_wdata;
    logic [GRID_SIDE-1:0] row_mask;

    logic [CW-1:0]          wm1, hm1, cx_c, cy_c, y0_c, y1_c;
    logic [CELL_SUM_W-1:0]  cxs, cys;
    logic [CFG_W-1:0]       r_c;
    logic [2*CFG_W-1:0]     rsq;
    logic [CRW-1:0]         cr_c;
    logic signed [COLW-1:0] ys, ye, col_init;
    logic signed [DXW-1:0]  dy_c;
    logic [KW-1:0]          kd;
    logic                   lane_ok, is_peak;
    logic [SQ_W-1:0]        lane_sq;

    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = M_TDATA_W'(peak_reg);
    assign s_tready  = (state_reg == ST_IDLE);

    // Geometry of the current point.
    always_comb begin
        wm1 = (grid_width_reg == '0) ? '0 :
              (int'(grid_width_reg) > GRID_SIDE) ? CW'(GRID_SIDE - 1) :
              CW'(grid_width_reg - 9'd1);
        hm1 = (grid_height_reg == '0) ? '0 :
              (int'(grid_height_reg) > GRID_SIDE) ? CW'(GRID_SIDE - 1) :
              CW'(grid_height_reg - 9'd1);
        cxs  = (CELL_SUM_W'(px_reg) + CELL_SUM_W'(HALF)) >> SUBCELL_BITS;
        cys  = (CELL_SUM_W'(py_reg) + CELL_SUM_W'(HALF)) >> SUBCELL_BITS;
        cx_c = (cxs > CELL_SUM_W'(wm1)) ? wm1 : CW'(cxs);
        cy_c = (cys > CELL_SUM_W'(hm1)) ? hm1 : CW'(cys);
        r_c  = (int'(radius_reg) > RLIM) ? CFG_W'(RLIM) : radius_reg;
        rsq  = r_c * r_c;
        cr_c = CRW'((int'(r_c) + S - 1) >> SUBCELL_BITS);
        ys   = COLW'(cy_c) - COLW'(cr_c);
        ye   = COLW'(cy_c) + COLW'(cr_c);
        y0_c = ys[COLW-1] ? '0 : CW'(ys);
        y1_c = (ye > COLW'(hm1)) ? hm1 : CW'(ye);
        col_init = COLW'(cx_c) - COLW'(MAX_RADIUS_CELLS);
        kd = (k_reg >= KW'(MAX_RADIUS_CELLS)) ? k_reg - KW'(MAX_RADIUS_CELLS)
                                               : KW'(MAX_RADIUS_CELLS) - k_reg;
        lane_ok = !col_reg[COLW-1] && (col_reg <= COLW'(wm1)) && (kd <= KW'(cr_reg));
        lane_sq = sq_clamp(32'(dx_reg));
        dy_c = (DXW'(row_reg) << (SUBCELL_BITS + 1)) + DXW'(S) - (DXW'(py_reg) << 1);
        is_peak = !rd_data_reg[cx_reg];
    end

    always_comb begin
        state_next       = state_reg;
        radius_next      = radius_reg;
        grid_width_next  = grid_width_reg;
        grid_height_next = grid_height_reg;
        row_next         = row_reg;
        st1_valid_next   = 1'b0;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        px_next   = px_reg;
        py_next   = py_reg;
        idx_next  = idx_reg;
        peak_next = peak_reg;
        cx_next   = cx_reg;
        y1_next   = y1_reg;
        cr_next   = cr_reg;
        lim_next  = lim_reg;
        k_next    = k_reg;
        dx_next   = dx_reg;
        col_next  = col_reg;
        dysq_next = dysq_reg;
        st1_row_next = row_reg;
        mem_re    = 1'b0;
        mem_raddr = row_reg;
        mem_we    = 1'b0;
        mem_waddr = st1_row_reg;
        mem_wdata = rd_data_reg | row_mask;

        if (cfg_valid) begin
            case (cfg_index)
                REG_RADIUS:      radius_next      = cfg_data;
                REG_GRID_WIDTH:  grid_width_next  = cfg_data;
                REG_GRID_HEIGHT: grid_height_next = cfg_data;
                default: ;
            endcase
        end

        if (st1_valid_reg) begin
            mem_we = 1'b1;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = row_reg;
                mem_wdata = '0;
                row_next  = row_reg + 1'b1;
                if (row_reg == CW'(GRID_SIDE - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (s_tuser) begin
                        row_next   = '0;
                        state_next = ST_CLEAR;
                    end else begin
                        px_next    = s_tdata[COORD_W-1:0];
                        py_next    = s_tdata[2*COORD_W-1:COORD_W];
                        idx_next   = s_tdata[2*COORD_W+INDEX_W-1:2*COORD_W];
                        state_next = ST_SETUP;
                    end
                end
            end
            ST_SETUP: begin
                mem_re    = 1'b1;
                mem_raddr = cy_c;
                cx_next   = cx_c;
                y1_next   = y1_c;
                row_next  = y0_c;
                cr_next   = cr_c;
                lim_next  = {rsq, 2'b00};
                k_next    = '0;
                col_next  = col_init;
                dx_next   = (DXW'(col_init) <<< (SUBCELL_BITS + 1)) + DXW'(S)
                            - (DXW'(px_reg) << 1);
                state_next = ST_LANES;
            end
            ST_LANES: begin
                k_next   = k_reg + 1'b1;
                col_next = col_reg + COLW'(1);
                dx_next  = dx_reg + DXW'(2 * S);
                if (k_reg == KW'(NL - 1)) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (!is_peak) begin
                    state_next = ST_MARK;
                end else if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    peak_next     = idx_reg;
                    state_next    = ST_MARK;
                end
            end
            ST_MARK: begin
                mem_re         = 1'b1;
                st1_valid_next = 1'b1;
                dysq_next      = sq_clamp(32'(dy_c));
                row_next       = row_reg + 1'b1;
                if (row_reg == y1_reg) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_CLEAR;
            row_reg         <= '0;
            st1_valid_reg   <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            radius_reg      <= RADIUS_RESET;
            grid_width_reg  <= GRID_WIDTH_RESET;
            grid_height_reg <= GRID_HEIGHT_RESET;
        end else begin
            state_reg       <= state_next;
            row_reg         <= row_next;
            st1_valid_reg   <= st1_valid_next;
            m_tvalid_reg    <= m_tvalid_next;
            radius_reg      <= radius_next;
            grid_width_reg  <= grid_width_next;
            grid_height_reg <= grid_height_next;
        end
    end

    always_ff @(posedge aclk) begin
        px_reg      <= px_next;
        py_reg      <= py_next;
        idx_reg     <= idx_next;
        peak_reg    <= peak_next;
        cx_reg      <= cx_next;
        y1_reg      <= y1_next;
        cr_reg      <= cr_next;
        lim_reg     <= lim_next;
        k_reg       <= k_next;
        dx_reg      <= dx_next;
        col_reg     <= col_next;
        dysq_reg    <= dysq_next;
        st1_row_reg <= st1_row_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mark_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mark_mem[mem_raddr];
        end
    end

    gps_disc_lanes #(
        .GRID_SIDE        (GRID_SIDE),
        .MAX_RADIUS_CELLS (MAX_RADIUS_CELLS)
    ) u_lanes (
        .aclk     (aclk),
        .push     (state_reg == ST_LANES),
        .push_sq  (lane_sq),
        .push_ok  (lane_ok),
        .dysq     (dysq_reg),
        .lim      (lim_reg),
        .cx       (cx_reg),
        .row_mask (row_mask)
    );

`ifndef SYNTHESIS
    a_st1_in_mark: assert property (@(posedge aclk) disable iff (!aresetn)
        st1_valid_reg |-> (state_reg == ST_MARK || state_reg == ST_DRAIN))
        else $error("row write outside the marking pass");

    a_idle_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !st1_valid_reg)
        else $error("word accepted while a row write is pending");

    a_no_row_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("read and write of the same map row in one cycle");

    a_clear_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser) |=> (state_reg == ST_CLEAR && row_reg == '0))
        else $error("clear word did not start the sweep");
`endif

endmodule

// ----- tb/sv/tb_grid_peak_suppression_unit.sv -----
// Self-checking testbench for grid_peak_suppression_unit: streams points and clear words,
// predicts the peaks with its own mark map and compares every result word.
// Depends on gps_pkg and the RTL of the unit.
module tb_grid_peak_suppression_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import gps_pkg::*;

    localparam int GRID_SIDE    = DEF_GRID_SIDE;
    localparam int SUB_BITS     = DEF_SUBCELL_BITS;
    localparam int MAX_RAD      = DEF_MAX_RADIUS_CELLS << DEF_SUBCELL_BITS;
    localparam int SETTLE_CYCLES = 400;
    localparam int LONG_HOLD    = 600;

    typedef struct {
        logic               clear_map;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [INDEX_W-1:0] index;
        bit                 wait_quiet;
    } map_word_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_W-1:0]       cfg_data = '0;

    grid_peak_suppression_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    map_word_t          pending_words[$];
    logic [INDEX_W-1:0] expected_peaks[$];
    logic [GRID_SIDE-1:0] mark_rows [GRID_SIDE];
    logic [CFG_W-1:0]   radius_reg = RADIUS_RESET;
    logic [CFG_W-1:0]   width_reg  = GRID_WIDTH_RESET;
    logic [CFG_W-1:0]   height_reg = GRID_HEIGHT_RESET;
    int                 error_count = 0;
    bit                 sender_idles = 1'b1;
    bit                 receiver_idles = 1'b1;
    int                 hold_requests = 0;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        foreach (mark_rows[r]) mark_rows[r] = '0;
    end

    function automatic int grid_extent(input logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > GRID_SIDE) return GRID_SIDE;
        return int'(v);
    endfunction

    function automatic int cell_of(input logic [COORD_W-1:0] c, input int extent);
        int cell_idx;
        cell_idx = (int'(c) + ((1 << SUB_BITS) >> 1)) >> SUB_BITS;
        return (cell_idx > extent - 1) ? extent - 1 : cell_idx;
    endfunction

    // Updates the mark map for one word and tells whether it yields a peak.
    function automatic bit predict_peak(input map_word_t w);
        int gw, gh, cx, cy, rad, win, lim, dx, dy;
        int x0, x1, y0, y1;
        bit peak;
        if (w.clear_map) begin
            foreach (mark_rows[r]) mark_rows[r] = '0;
            return 1'b0;
        end
        gw = grid_extent(width_reg);
        gh = grid_extent(height_reg);
        cx = cell_of(w.x, gw);
        cy = cell_of(w.y, gh);
        peak = !mark_rows[cy][cx];
        rad = (int'(radius_reg) > MAX_RAD) ? MAX_RAD : int'(radius_reg);
        win = (rad + (1 << SUB_BITS) - 1) >> SUB_BITS;
        lim = 4 * rad * rad;
        x0 = (cx - win < 0) ? 0 : cx - win;
        x1 = (cx + win > gw - 1) ? gw - 1 : cx + win;
        y0 = (cy - win < 0) ? 0 : cy - win;
        y1 = (cy + win > gh - 1) ? gh - 1 : cy + win;
        for (int j = y0; j <= y1; j++) begin
            dy = 2 * j * (1 << SUB_BITS) + (1 << SUB_BITS) - 2 * int'(w.y);
            for (int i = x0; i <= x1; i++) begin
                dx = 2 * i * (1 << SUB_BITS) + (1 << SUB_BITS) - 2 * int'(w.x);
                if (dx * dx + dy * dy < lim) mark_rows[j][i] = 1'b1;
            end
        end
        return peak;
    endfunction

    // Driver: offers pending words, with random gaps after each accepted one while sender_idles is set.
    map_word_t cur_word;
    int        send_gap = 0;

    always @(posedge aclk) begin
        bit offering;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            offering = s_tvalid;
            if (s_tvalid && s_tready) begin
                if (predict_peak(cur_word))
                    expected_peaks.insert(expected_peaks.size(), cur_word.index);
                offering = 1'b0;
                send_gap = sender_idles ? $urandom_range(0, 14) : 0;
            end
            if (!offering) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_words.size() > 0 &&
                             !(pending_words[0].wait_quiet && expected_peaks.size() != 0)) begin
                    cur_word = pending_words.pop_front();
                    s_tdata  <= S_TDATA_W'({cur_word.index, cur_word.y, cur_word.x});
                    s_tuser  <= cur_word.clear_map;
                    offering = 1'b1;
                end
            end
            s_tvalid <= offering;
        end
    end

    // Monitor: checks each result word; stalls the output at random and on hold requests.
    int stall_left = 0;
    int holds_served = 0;

    always @(posedge aclk) begin
        logic [INDEX_W-1:0] want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_peaks.size() == 0) begin
                    $display("%0t: unexpected peak, expected none, actual %05h",
                             $time, m_tdata[INDEX_W-1:0]);
                    error_count++;
                end else begin
                    want = expected_peaks.pop_front();
                    if (m_tdata[INDEX_W-1:0] !== want) begin
                        $display("%0t: peak_index mismatch, expected %05h, actual %05h",
                                 $time, want, m_tdata[INDEX_W-1:0]);
                        error_count++;
                    end
                end
                stall_left = receiver_idles ? $urandom_range(0, 14) : 0;
            end
            if (holds_served != hold_requests) begin
                holds_served++;
                stall_left = LONG_HOLD;
            end
            m_tready <= (stall_left == 0);
            if (stall_left > 0) stall_left--;
        end
    end

    task automatic push_word(input logic clear_map, input int x, input int y, input int index,
                             input bit wait_quiet = 1'b0);
        map_word_t w;
        w.clear_map  = clear_map;
        w.x          = COORD_W'(x);
        w.y          = COORD_W'(y);
        w.index      = INDEX_W'(index);
        w.wait_quiet = wait_quiet;
        pending_words.insert(pending_words.size(), w);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_RADIUS:      radius_reg = CFG_W'(value);
            REG_GRID_WIDTH:  width_reg  = CFG_W'(value);
            REG_GRID_HEIGHT: height_reg = CFG_W'(value);
            default: ;
        endcase
    endtask

    task automatic wait_quiet_map();
        while (!(pending_words.size() == 0 && !s_tvalid && expected_peaks.size() == 0))
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic int pick_size();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 1;
            2: return 256;
            3: return $urandom_range(257, 511);
            4: return $urandom_range(2, 8);
            default: return $urandom_range(1, 256);
        endcase
    endfunction

    function automatic int pick_radius();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 1;
            2: return 256;
            3: return $urandom_range(257, 511);
            4: return $urandom_range(15, 17);
            default: return $urandom_range(2, 255);
        endcase
    endfunction

    task automatic random_phase(input int count, input bit long_hold, input bit with_pause);
        int span_x, span_y, x, y;
        span_x = grid_extent(width_reg) * (1 << SUB_BITS) + 31;
        span_y = grid_extent(height_reg) * (1 << SUB_BITS) + 31;
        if (span_x > 4095) span_x = 4095;
        if (span_y > 4095) span_y = 4095;
        if (long_hold) hold_requests++;
        if ($urandom_range(0, 1) == 1) push_word(1'b1, $urandom, $urandom, $urandom);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 24) == 0) begin
                push_word(1'b1, $urandom, $urandom, $urandom);
            end else begin
                if ($urandom_range(0, 9) == 0) begin
                    x = $urandom_range(0, 4095);
                    y = $urandom_range(0, 4095);
                end else begin
                    x = $urandom_range(0, span_x);
                    y = $urandom_range(0, span_y);
                end
                push_word(1'b0, x, y, $urandom, with_pause && n == count / 2);
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        push_word(1'b0, 0, 0, 0);
        push_word(1'b0, 0, 0, 1);
        push_word(1'b0, 4095, 4095, 20'hFFFFF);
        push_word(1'b0, 8, 8, 2);
        push_word(1'b0, 7, 7, 3);
        push_word(1'b1, 4095, 4095, 20'hFFFFF);
        push_word(1'b0, 0, 0, 4);
        push_word(1'b0, 2048, 1024, 20'h55555);
        push_word(1'b0, 2048 + 160, 1024, 20'hAAAAA);
        push_word(1'b0, 2048, 1024 + 152, 5);
        push_word(1'b1, 0, 0, 0);
        wait_quiet_map();

        write_reg(REG_RADIUS, 0);
        push_word(1'b0, 100, 100, 6);
        push_word(1'b0, 100, 100, 7);
        wait_quiet_map();

        write_reg(REG_RADIUS, 511);
        write_reg(REG_GRID_WIDTH, 0);
        write_reg(REG_GRID_HEIGHT, 511);
        push_word(1'b0, 4095, 0, 8);
        push_word(1'b0, 0, 4095, 9);
        push_word(1'b0, 0, 2560, 10);
        wait_quiet_map();

        write_reg(REG_RADIUS, 1);
        write_reg(REG_GRID_WIDTH, 511);
        write_reg(REG_GRID_HEIGHT, 0);
        push_word(1'b0, 4095, 4095, 11);
        push_word(1'b0, 4088, 4095, 12);
        push_word(1'b0, 1000, 0, 13);
        push_word(1'b0, 1000, 0, 14);
        wait_quiet_map();

        for (int p = 0; p < 8; p++) begin
            write_reg(REG_RADIUS, pick_radius());
            write_reg(REG_GRID_WIDTH, pick_size());
            write_reg(REG_GRID_HEIGHT, pick_size());
            sender_idles   = (p == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
            receiver_idles = ($urandom_range(0, 3) != 0);
            random_phase(75, p == 2, p == 4);
            wait_quiet_map();
        end

        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/gps_pkg.sv
rtl/core/gps_disc_lanes.sv
rtl/core/grid_peak_suppression_unit.sv
tb/sv/tb_grid_peak_suppression_unit.sv
